/* hdl/fctp_pkg.sv */
// Package for the flow classifier / token policer.
// Holds opcodes, verdict and action codes, shared with the top level and the match unit.
package fctp_pkg;

  typedef enum logic [2:0] {
    OP_BYTE      = 3'd0,
    OP_FLOW_WR   = 3'd1,
    OP_ACTION    = 3'd2,
    OP_TOKENS    = 3'd3,
    OP_FLOW_CLR  = 3'd4
  } opcode_e;

  typedef enum logic [2:0] {
    V_ABORTED  = 3'd0,
    V_DROP     = 3'd1,
    V_PASS     = 3'd2,
    V_TX       = 3'd3,
    V_REDIRECT = 3'd4
  } verdict_e;

  localparam logic [1:0] ACT_PASS  = 2'd0;
  localparam logic [1:0] ACT_LIMIT = 2'd1;
  localparam logic [1:0] ACT_DROP  = 2'd2;
  localparam logic [1:0] ACT_OTHER = 2'd3;

  localparam logic [15:0] ETH_IPV4   = 16'h0800;
  localparam logic [7:0]  PROTO_TCP  = 8'd6;
  localparam logic [7:0]  PROTO_UDP  = 8'd17;
  localparam logic [2:0]  SAMPLE_MOD = 3'd7;

  typedef struct packed {
    logic [31:0] saddr;
    logic [31:0] daddr;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [7:0]  proto;
  } tuple_t;

endpackage

/* hdl/fctp_match.sv */
// Flow table: key store, valid bits and contract targets, with a parallel match.
// Depends on fctp_pkg.
module fctp_match #(
  parameter int FlowSlots = 16,
  parameter int SlotW     = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  logic             clr_i,
  input  logic [SlotW-1:0] slot_i,
  input  fctp_pkg::tuple_t wr_key_i,
  input  logic [7:0]       wr_target_i,
  input  fctp_pkg::tuple_t key_i,
  output logic             hit_o,
  output logic [7:0]       target_o
);
  import fctp_pkg::*;

  tuple_t           key_q    [FlowSlots];
  logic [7:0]       target_q [FlowSlots];
  logic [FlowSlots-1:0] valid_q;

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_i) begin
      valid_q[slot_i] <= 1'b1;
    end else if (clr_i) begin
      valid_q[slot_i] <= 1'b0;
    end
  end

  // Key and target store
  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      key_q[slot_i]    <= wr_key_i;
      target_q[slot_i] <= wr_target_i;
    end
  end

  // Lowest matching valid slot wins
  always_comb begin
    hit_o    = 1'b0;
    target_o = '0;
    for (int i = FlowSlots - 1; i >= 0; i--) begin
      if (valid_q[i] && key_q[i] == key_i) begin
        hit_o    = 1'b1;
        target_o = target_q[i];
      end
    end
  end

endmodule

/* hdl/flow_classifier_token_policer_core.sv */
// Top level of the flow classifier / token policer.
// Depends on fctp_pkg and fctp_match.
//
//  channel | signals                      | direction
//  in      | in_valid_i / in_ready_o      | frame bytes and table commands
//  out     | out_valid_o / out_ready_i    | one verdict per final frame byte
//
// Each request is parsed from the input register; a final byte's verdict is registered and
// shown in the following cycle. One request per cycle is taken while the result
// register is empty or being drained. Reset clears parse state, sampling phase,
// flow valid bits, contract actions and tokens. An unread result stalls input.
module flow_classifier_token_policer_core #(
  parameter int FLOW_SLOTS     = 16,
  parameter int CONTRACT_COUNT = 16,
  parameter int MAX_FRAME_LEN  = 16383
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  opcode_i,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  input  logic [4:0]  rx_queue_i,
  input  logic [3:0]  slot_i,
  input  logic [62:0] value_i,
  input  logic [31:0] src_addr_i,
  input  logic [31:0] dst_addr_i,
  input  logic [15:0] src_port_i,
  input  logic [15:0] dst_port_i,
  input  logic [7:0]  proto_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  verdict_o,
  output logic [4:0]  redirect_queue_o
);
  import fctp_pkg::*;

  localparam int SlotW  = (FLOW_SLOTS > 1) ? $clog2(FLOW_SLOTS) : 1;
  localparam int CtrW   = (CONTRACT_COUNT > 1) ? $clog2(CONTRACT_COUNT) : 1;
  localparam int LenW   = $clog2(MAX_FRAME_LEN + 1);
  localparam logic [LenW-1:0] MaxLen = LenW'(MAX_FRAME_LEN);

  // Input register
  logic        req_q;
  opcode_e     op_q;
  logic [7:0]  byte_q;
  logic        last_q;
  logic [4:0]  queue_q;
  logic [3:0]  slot_q;
  logic [62:0] value_q;
  tuple_t      wkey_q;

  logic accept;
  logic stall;
  assign stall      = out_valid_o && !out_ready_i;
  assign in_ready_o = !stall;
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_q <= 1'b0;
    end else if (!stall) begin
      req_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= opcode_e'(opcode_i);
      byte_q  <= data_byte_i;
      last_q  <= last_byte_i;
      queue_q <= rx_queue_i;
      slot_q  <= slot_i;
      value_q <= value_i;
      wkey_q  <= '{saddr: src_addr_i, daddr: dst_addr_i, sport: src_port_i,
                   dport: dst_port_i, proto: proto_i};
    end
  end

  // Work happens when the stage holds a request and the result side is free
  logic go;
  assign go = req_q && !stall;

  // Parse state
  logic [LenW-1:0] off_q;
  logic [3:0]      ihl_q;
  logic [15:0]     etype_q;
  logic [7:0]      ipp_q;
  logic [31:0]     ips_q, ipd_q;
  logic [15:0]     l4s_q, l4d_q;
  logic [2:0]      phase_q;

  logic [LenW-1:0] off_d;
  logic [3:0]      ihl_d;
  logic [15:0]     etype_d;
  logic [7:0]      ipp_d;
  logic [31:0]     ips_d, ipd_d;
  logic [15:0]     l4s_d, l4d_d;
  logic [LenW-1:0] len;
  logic [LenW:0]   l4start;
  logic [LenW:0]   pos_x;
  logic            frame_byte;

  assign frame_byte = go && (op_q == OP_BYTE);
  assign l4start    = (LenW+1)'(14) + {{(LenW-5){1'b0}}, ihl_q, 2'b00};
  assign pos_x      = {1'b0, off_q};

  always_comb begin
    off_d   = off_q;
    ihl_d   = ihl_q;
    etype_d = etype_q;
    ipp_d   = ipp_q;
    ips_d   = ips_q;
    ipd_d   = ipd_q;
    l4s_d   = l4s_q;
    l4d_d   = l4d_q;
    len     = MaxLen;
    if (off_q < MaxLen) begin
      len   = off_q + LenW'(1);
      off_d = off_q + LenW'(1);
      if (off_q == LenW'(12) || off_q == LenW'(13)) etype_d = {etype_q[7:0], byte_q};
      if (off_q == LenW'(14)) ihl_d = byte_q[3:0];
      if (off_q == LenW'(23)) ipp_d = byte_q;
      if (off_q >= LenW'(26) && off_q <= LenW'(29)) ips_d = {ips_q[23:0], byte_q};
      if (off_q >= LenW'(30) && off_q <= LenW'(33)) ipd_d = {ipd_q[23:0], byte_q};
      if (off_q >= LenW'(14)) begin
        if (pos_x == l4start || pos_x == l4start + (LenW+1)'(1))
          l4s_d = {l4s_q[7:0], byte_q};
        if (pos_x == l4start + (LenW+1)'(2) || pos_x == l4start + (LenW+1)'(3))
          l4d_d = {l4d_q[7:0], byte_q};
      end
    end
  end

  // Flow key of the frame ending now
  tuple_t fkey;
  logic   is_l4;
  assign is_l4 = (ipp_d == PROTO_TCP) || (ipp_d == PROTO_UDP);
  assign fkey  = '{saddr: ips_d, daddr: ipd_d, sport: is_l4 ? l4s_d : 16'd0,
                   dport: is_l4 ? l4d_d : 16'd0, proto: ipp_d};

  logic       hit;
  logic [7:0] target;
  logic       slot_ok_f, slot_ok_c;
  assign slot_ok_f = {28'd0, slot_q} < 32'(FLOW_SLOTS);
  assign slot_ok_c = {28'd0, slot_q} < 32'(CONTRACT_COUNT);

  fctp_match #(.FlowSlots(FLOW_SLOTS), .SlotW(SlotW)) u_match (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_i        (go && op_q == OP_FLOW_WR && slot_ok_f),
    .clr_i       (go && op_q == OP_FLOW_CLR && slot_ok_f),
    .slot_i      (SlotW'(slot_q)),
    .wr_key_i    (wkey_q),
    .wr_target_i ((value_q > 63'd255) ? 8'hFF : value_q[7:0]),
    .key_i       (fkey),
    .hit_o       (hit),
    .target_o    (target)
  );

  // Contracts
  logic [1:0]  act_q [CONTRACT_COUNT];
  logic [62:0] tok_q [CONTRACT_COUNT];
  logic [CtrW-1:0] cidx;
  logic        cidx_ok;
  assign cidx_ok = {24'd0, target} < 32'(CONTRACT_COUNT);
  assign cidx    = target[CtrW-1:0];

  logic [LenW+3:0] need;
  logic            tok_ok;
  assign need   = {(LenW+1)'(len) + (LenW+1)'(4), 3'b000};
  assign tok_ok = tok_q[cidx] >= 63'(need);

  // Verdict
  logic [2:0] phase_n;
  verdict_e   pol;
  logic       debit;
  logic [LenW:0] l4min;
  assign phase_n = (phase_q == SAMPLE_MOD - 3'd1) ? 3'd0 : phase_q + 3'd1;

  always_comb begin
    pol   = V_TX;
    debit = 1'b0;
    l4min = l4start + ((ipp_d == PROTO_TCP) ? (LenW+1)'(20) : (LenW+1)'(8));
    if (len < LenW'(14)) begin
      pol = V_ABORTED;
    end else if (etype_d != ETH_IPV4) begin
      pol = V_TX;
    end else if (len < LenW'(34)) begin
      pol = V_ABORTED;
    end else if (is_l4 && {1'b0, len} < l4min) begin
      pol = V_ABORTED;
    end else if (!hit || !cidx_ok) begin
      pol = V_DROP;
    end else begin
      case (act_q[cidx])
        ACT_PASS:  pol = V_PASS;
        ACT_DROP:  pol = V_DROP;
        ACT_LIMIT: begin
          pol   = tok_ok ? V_TX : V_DROP;
          debit = tok_ok;
        end
        default:   pol = V_TX;
      endcase
    end
  end

  logic frame_end;
  assign frame_end = frame_byte && last_q;

  // Parse and phase registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q   <= '0;
      ihl_q   <= '0;
      etype_q <= '0;
      ipp_q   <= '0;
      ips_q   <= '0;
      ipd_q   <= '0;
      l4s_q   <= '0;
      l4d_q   <= '0;
      phase_q <= '0;
    end else if (frame_end) begin
      off_q   <= '0;
      ihl_q   <= '0;
      etype_q <= '0;
      ipp_q   <= '0;
      ips_q   <= '0;
      ipd_q   <= '0;
      l4s_q   <= '0;
      l4d_q   <= '0;
      phase_q <= phase_n;
    end else if (frame_byte) begin
      off_q   <= off_d;
      ihl_q   <= ihl_d;
      etype_q <= etype_d;
      ipp_q   <= ipp_d;
      ips_q   <= ips_d;
      ipd_q   <= ipd_d;
      l4s_q   <= l4s_d;
      l4d_q   <= l4d_d;
    end
  end

  // Contract tables
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CONTRACT_COUNT; i++) begin
        act_q[i] <= ACT_PASS;
        tok_q[i] <= '0;
      end
    end else if (go && op_q == OP_ACTION && slot_ok_c) begin
      act_q[CtrW'(slot_q)] <= (value_q > 63'd3) ? ACT_OTHER : value_q[1:0];
    end else if (go && op_q == OP_TOKENS && slot_ok_c) begin
      tok_q[CtrW'(slot_q)] <= value_q;
    end else if (frame_end && phase_n == 3'd0 && debit) begin
      tok_q[cidx] <= tok_q[cidx] - 63'(need);
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (!stall) begin
      out_valid_o <= frame_end;
    end
  end

  always_ff @(posedge clk_i) begin
    if (frame_end) begin
      if (phase_n != 3'd0) begin
        verdict_o        <= V_REDIRECT;
        redirect_queue_o <= queue_q;
      end else begin
        verdict_o        <= pol;
        redirect_queue_o <= '0;
      end
    end
  end

endmodule

/* tb/flow_classifier_token_policer_core_tb.sv */
// Testbench for flow_classifier_token_policer_core: directed table with fixed expected
// verdicts, then random frames and table commands checked against a built-in policer predictor.
// Depends on fctp_pkg and the RTL of the core.
`timescale 1ns / 1ps

module flow_classifier_token_policer_core_tb;
  import fctp_pkg::*;

  localparam int SLOTS      = 16;
  localparam int CONTRACTS  = 16;
  localparam int MAX_LEN    = 16383;
  localparam int NUM_RAND   = 1250;
  localparam int IDLE_LIMIT = 20000;
  localparam int HOLD_LEN   = 300;
  localparam int POOL_SZ    = 6;
  localparam logic [2:0] OP_SPARE_LO = 3'd5;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  typedef struct {
    logic [2:0]  op;
    logic [7:0]  data;
    logic        last;
    logic [4:0]  q;
    logic [3:0]  slot;
    logic [62:0] val;
    tuple_t      key;
    bit          has_exp;
    verdict_e    v;
    logic [4:0]  rq;
  } req_t;

  typedef struct {
    verdict_e   v;
    logic [4:0] rq;
  } verdict_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [2:0]  opcode_i = OP_BYTE;
  logic [7:0]  data_byte_i = '0;
  logic        last_byte_i = 1'b0;
  logic [4:0]  rx_queue_i = '0;
  logic [3:0]  slot_i = '0;
  logic [62:0] value_i = '0;
  logic [31:0] src_addr_i = '0;
  logic [31:0] dst_addr_i = '0;
  logic [15:0] src_port_i = '0;
  logic [15:0] dst_port_i = '0;
  logic [7:0]  proto_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [2:0]  verdict_o;
  logic [4:0]  redirect_queue_o;

  flow_classifier_token_policer_core DUT (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // predictor state
  logic [13:0] p_off;
  logic [3:0]  p_ihl;
  logic [15:0] p_etype;
  logic [7:0]  p_proto;
  logic [31:0] p_src, p_dst;
  logic [15:0] p_sport, p_dport;
  int          p_phase;
  tuple_t      flow_keys [SLOTS];
  bit          flow_on [SLOTS];
  logic [7:0]  flow_contract [SLOTS];
  logic [1:0]  contract_act [CONTRACTS];
  logic [62:0] contract_tok [CONTRACTS];

  req_t     stim_q[$];
  verdict_t verdict_q[$];
  tuple_t   pool [POOL_SZ];
  int       n_acc = 0;
  int       errors = 0;
  bit       quiet = 0;
  int       frames = 0;

  task automatic report(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic void clear_parse();
    p_off = '0; p_ihl = '0; p_etype = '0; p_proto = '0;
    p_src = '0; p_dst = '0; p_sport = '0; p_dport = '0;
  endfunction

  function automatic void capture_byte(input int pos, input logic [7:0] b);
    int start;
    if (pos == 12 || pos == 13) p_etype = {p_etype[7:0], b};
    if (pos == 14) p_ihl = b[3:0];
    if (pos == 23) p_proto = b;
    if (pos >= 26 && pos <= 29) p_src = {p_src[23:0], b};
    if (pos >= 30 && pos <= 33) p_dst = {p_dst[23:0], b};
    if (pos >= 14) begin
      start = 14 + 4 * int'(p_ihl);
      if (pos == start || pos == start + 1) p_sport = {p_sport[7:0], b};
      if (pos == start + 2 || pos == start + 3) p_dport = {p_dport[7:0], b};
    end
  endfunction

  // verdict of a sampled frame
  function automatic verdict_e police_frame(input int len);
    tuple_t k;
    int start, hit, idx;
    logic [63:0] need;
    start = 14 + 4 * int'(p_ihl);
    hit = -1;
    if (len < 14) return V_ABORTED;
    if (p_etype != ETH_IPV4) return V_TX;
    if (len < 34) return V_ABORTED;
    k.sport = '0;
    k.dport = '0;
    if (p_proto == PROTO_TCP) begin
      if (len < start + 20) return V_ABORTED;
      k.sport = p_sport; k.dport = p_dport;
    end else if (p_proto == PROTO_UDP) begin
      if (len < start + 8) return V_ABORTED;
      k.sport = p_sport; k.dport = p_dport;
    end
    k.saddr = p_src; k.daddr = p_dst; k.proto = p_proto;
    for (int i = 0; i < SLOTS; i++)
      if (hit < 0 && flow_on[i] && flow_keys[i] == k) hit = i;
    if (hit < 0) return V_DROP;
    idx = int'(flow_contract[hit]);
    if (idx >= CONTRACTS) return V_DROP;
    case (contract_act[idx])
      ACT_PASS: return V_PASS;
      ACT_DROP: return V_DROP;
      ACT_LIMIT: begin
        need = (64'(len) + 64'd4) * 64'd8;
        if ({1'b0, contract_tok[idx]} >= need) begin
          contract_tok[idx] = contract_tok[idx] - need[62:0];
          return V_TX;
        end
        return V_DROP;
      end
      default: return V_TX;
    endcase
  endfunction

  // advance the predictor by one request; returns 1 when a verdict is due
  function automatic bit police_step(input req_t r, output verdict_t res);
    int pos, len;
    res.v = V_ABORTED;
    res.rq = '0;
    case (r.op)
      OP_FLOW_WR: begin
        flow_keys[r.slot] = r.key;
        flow_contract[r.slot] = (r.val > 63'd255) ? 8'd255 : r.val[7:0];
        flow_on[r.slot] = 1'b1;
        return 0;
      end
      OP_ACTION: begin
        contract_act[r.slot] = (r.val > 63'd3) ? ACT_OTHER : r.val[1:0];
        return 0;
      end
      OP_TOKENS: begin
        contract_tok[r.slot] = r.val;
        return 0;
      end
      OP_FLOW_CLR: begin
        flow_on[r.slot] = 1'b0;
        return 0;
      end
      OP_BYTE: ;
      default: return 0;
    endcase
    pos = int'(p_off);
    if (pos < MAX_LEN) begin
      capture_byte(pos, r.data);
      p_off = 14'(pos + 1);
      len = pos + 1;
    end else begin
      len = MAX_LEN;
    end
    if (!r.last) return 0;
    p_phase = (p_phase + 1) % 7;
    if (p_phase != 0) begin
      res.v = V_REDIRECT;
      res.rq = r.q;
    end else begin
      res.v = police_frame(len);
    end
    clear_parse();
    return 1;
  endfunction

  function automatic tuple_t rand_tuple();
    tuple_t t;
    t.saddr = $urandom; t.daddr = $urandom;
    t.sport = 16'($urandom); t.dport = 16'($urandom);
    case ($urandom_range(0, 3))
      0: t.proto = PROTO_TCP;
      1: t.proto = PROTO_UDP;
      default: t.proto = 8'($urandom);
    endcase
    if (t.proto != PROTO_TCP && t.proto != PROTO_UDP) begin
      t.sport = '0; t.dport = '0;
    end
    return t;
  endfunction

  function automatic req_t rand_req(input logic [2:0] op);
    req_t r;
    r.op = op; r.data = 8'($urandom); r.last = 1'b0; r.q = 5'($urandom);
    r.slot = 4'($urandom); r.val = 63'({$urandom, $urandom});
    r.key.saddr = $urandom; r.key.daddr = $urandom; r.key.sport = 16'($urandom);
    r.key.dport = 16'($urandom); r.key.proto = 8'($urandom);
    r.has_exp = 0; r.v = V_ABORTED; r.rq = '0;
    return r;
  endfunction

  function automatic req_t mk(input logic [2:0] op, input logic [7:0] data, input logic last,
                              input logic [4:0] q, input logic [3:0] slot,
                              input logic [62:0] val);
    req_t r;
    r = rand_req(op);
    r.data = data; r.last = last; r.q = q; r.slot = slot; r.val = val;
    return r;
  endfunction

  function automatic req_t mkx(input logic [7:0] data, input logic [4:0] q,
                               input verdict_e v, input logic [4:0] rq);
    req_t r;
    r = mk(OP_BYTE, data, 1'b1, q, '0, '0);
    r.has_exp = 1; r.v = v; r.rq = rq;
    return r;
  endfunction

  // one frame; policed frames get a parseable header, len_force overrides length
  task automatic add_frame(input bit full, input int len_force);
    tuple_t t;
    logic [7:0] fb[];
    logic [4:0] q;
    int len, ihl, start, need, sz, r;
    req_t it;
    q = 5'($urandom);
    if (!full) begin
      len = $urandom_range(1, 4);
      fb = new[len];
      foreach (fb[i]) fb[i] = 8'($urandom);
    end else begin
      t = ($urandom_range(0, 4) == 0) ? rand_tuple() : pool[$urandom_range(0, POOL_SZ - 1)];
      ihl = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : 5;
      start = 14 + 4 * ihl;
      need = (t.proto == PROTO_TCP) ? start + 20 : (t.proto == PROTO_UDP) ? start + 8 : 34;
      if (need < 34) need = 34;
      r = $urandom_range(0, 9);
      if (len_force > 0) len = len_force;
      else if (r < 7) len = need + $urandom_range(0, 16);
      else if (r < 9) len = $urandom_range(1, need);
      else len = $urandom_range(1, 13);
      sz = (len > start + 4) ? len : start + 4;
      if (sz < 34) sz = 34;
      fb = new[sz];
      foreach (fb[i]) fb[i] = 8'($urandom);
      if ($urandom_range(0, 9) != 0) begin
        fb[12] = ETH_IPV4[15:8]; fb[13] = ETH_IPV4[7:0];
      end
      fb[14] = {4'h4, 4'(ihl)};
      fb[23] = t.proto;
      for (int i = 0; i < 4; i++) begin
        fb[26 + i] = t.saddr[31 - 8 * i -: 8];
        fb[30 + i] = t.daddr[31 - 8 * i -: 8];
      end
      fb[start] = t.sport[15:8]; fb[start + 1] = t.sport[7:0];
      fb[start + 2] = t.dport[15:8]; fb[start + 3] = t.dport[7:0];
    end
    for (int i = 0; i < len; i++) begin
      it = rand_req(OP_BYTE);
      it.data = fb[i]; it.q = q; it.last = (i == len - 1);
      stim_q.push_back(it);
    end
    frames++;
  endtask

  task automatic add_command();
    req_t it;
    it = rand_req(3'($urandom_range(OP_FLOW_WR, OP_FLOW_CLR)));
    case (it.op)
      OP_FLOW_WR: begin
        it.key = ($urandom_range(0, 3) == 0) ? rand_tuple() : pool[$urandom_range(0, POOL_SZ - 1)];
        if ($urandom_range(0, 5) != 0) it.val = 63'($urandom_range(0, 17));
      end
      OP_ACTION: if ($urandom_range(0, 5) != 0) it.val = 63'($urandom_range(0, 3));
      OP_TOKENS: if ($urandom_range(0, 2) != 0) it.val = 63'($urandom_range(0, 4000));
      default: ;
    endcase
    stim_q.push_back(it);
  endtask

  // stimulus build, reset and driving
  initial begin
    req_t dir_tbl[$];
    tuple_t ones;
    int gap;
    clear_parse();
    p_phase = 0;
    foreach (flow_on[i]) begin
      flow_on[i] = 0; flow_keys[i] = '0; flow_contract[i] = '0;
    end
    foreach (contract_act[i]) begin
      contract_act[i] = ACT_PASS; contract_tok[i] = '0;
    end
    foreach (pool[i]) pool[i] = rand_tuple();
    ones = '1;

    dir_tbl.push_back(mk(OP_FLOW_WR, 8'h00, 1'b0, 5'd0, 4'd15, '1));
    dir_tbl[$].key = ones;
    dir_tbl.push_back(mk(OP_ACTION, 8'hFF, 1'b1, 5'd31, 4'd0, '1));
    dir_tbl.push_back(mk(OP_TOKENS, 8'h00, 1'b0, 5'd0, 4'd15, '1));
    dir_tbl.push_back(mk(OP_TOKENS, 8'h00, 1'b0, 5'd0, 4'd15, '0));
    dir_tbl.push_back(mk(OP_FLOW_CLR, 8'h00, 1'b0, 5'd0, 4'd15, '0));
    dir_tbl.push_back(mk(OP_SPARE_LO, 8'hFF, 1'b1, 5'd31, 4'd15, '1));
    dir_tbl.push_back(mk(OP_SPARE_HI, 8'hFF, 1'b1, 5'd31, 4'd15, '1));
    dir_tbl.push_back(mk(OP_ACTION, 8'h00, 1'b0, 5'd0, 4'd0, '0));
    dir_tbl.push_back(mkx(8'h00, 5'd0, V_REDIRECT, 5'd0));
    dir_tbl.push_back(mkx(8'hFF, 5'd31, V_REDIRECT, 5'd31));
    dir_tbl.push_back(mkx(8'h5A, 5'd1, V_REDIRECT, 5'd1));
    dir_tbl.push_back(mkx(8'hA5, 5'd16, V_REDIRECT, 5'd16));
    dir_tbl.push_back(mkx(8'h0F, 5'd10, V_REDIRECT, 5'd10));
    dir_tbl.push_back(mkx(8'hF0, 5'd21, V_REDIRECT, 5'd21));
    // seventh frame is policed: one byte is far too short
    dir_tbl.push_back(mkx(8'hFF, 5'd31, V_ABORTED, 5'd0));
    foreach (dir_tbl[i]) stim_q.push_back(dir_tbl[i]);
    frames = 7;

    // random part: frames (only the policed ones carry a header), with commands and noise between
    while (stim_q.size() < dir_tbl.size() + NUM_RAND) begin
      case ($urandom_range(0, 9))
        0, 1, 2: add_command();
        3: stim_q.push_back(rand_req(3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI))));
        default:
          if ((frames + 1) % 7 == 0) begin
            add_frame(1, 0);
          end else begin
            add_frame(0, 0);
          end
      endcase
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (stim_q[i]) begin
      if (i > stim_q.size() - 150) quiet = 1;
      if (!quiet && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 7);
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      in_valid_i  <= 1'b1;
      opcode_i    <= stim_q[i].op;
      data_byte_i <= stim_q[i].data;
      last_byte_i <= stim_q[i].last;
      rx_queue_i  <= stim_q[i].q;
      slot_i      <= stim_q[i].slot;
      value_i     <= stim_q[i].val;
      src_addr_i  <= stim_q[i].key.saddr;
      dst_addr_i  <= stim_q[i].key.daddr;
      src_port_i  <= stim_q[i].key.sport;
      dst_port_i  <= stim_q[i].key.dport;
      proto_i     <= stim_q[i].key.proto;
      do @(posedge clk_i); while (!in_ready_o);
    end
    in_valid_i <= 1'b0;

    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (errors == 0) $display("[flow_classifier_token_policer_core] OK");
    else $display("[flow_classifier_token_policer_core] ERROR");
    $finish;
  end

  // result side: random stall bursts, one long hold-off to back up the input
  initial begin
    int hold;
    bit long_done;
    hold = 0;
    long_done = 0;
    forever begin
      @(posedge clk_i);
      if (!long_done && n_acc >= 400) begin
        long_done = 1;
        hold = HOLD_LEN;
      end
      if (hold > 0) begin
        hold--;
        out_ready_i <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        hold = $urandom_range(0, 6);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // accepted requests feed the predictor; accepted verdicts are checked
  always @(posedge clk_i) begin
    verdict_t res, want;
    if (rst_ni && in_valid_i && in_ready_o) begin
      if (police_step(stim_q[n_acc], res)) begin
        if (stim_q[n_acc].has_exp) begin
          res.v = stim_q[n_acc].v;
          res.rq = stim_q[n_acc].rq;
        end
        verdict_q.push_back(res);
      end
      n_acc++;
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (verdict_q.size() == 0) begin
        report($sformatf("verdict %0d with nothing pending", verdict_o));
      end else begin
        want = verdict_q.pop_front();
        if (verdict_o != want.v)
          report($sformatf("verdict %0d, want %s", verdict_o, want.v.name()));
        if (redirect_queue_o != want.rq)
          report($sformatf("redirect_queue %0d, want %0d", redirect_queue_o, want.rq));
      end
    end
  end

  // watchdog on stalled traffic
  always @(posedge clk_i) begin
    int idle;
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle = 0;
    else idle++;
    if (idle >= IDLE_LIMIT) begin
      $display("[flow_classifier_token_policer_core] ERROR");
      $finish;
    end
  end

endmodule
